// ===== hw/rtl/zero_cross_gain_with_peak_assert.svh =====
// Assertion macros shared by the gain stage RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ZERO_CROSS_GAIN_WITH_PEAK_ASSERT_SVH
`define ZERO_CROSS_GAIN_WITH_PEAK_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checks prop at every rising edge of clk, except while reset is asserted.
`define ZCG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Checks that cons holds in the cycle after ante.
`define ZCG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ZCG_ASSERT(lbl, prop, msg)
`define ZCG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/zcg_pkg.sv =====
package zcg_pkg;

	localparam int SampleBits      = 24;
	localparam int GainBits        = 17;
	localparam int GainFracBits    = 16;
	localparam int ChannelsDefault = 2;
	localparam int CfgIdxBits      = 1;

	localparam logic [GainBits-1:0] GainReset = GainBits'(53084);

	// Configuration register indexes.
	localparam logic [CfgIdxBits-1:0] CfgTargetCh0 = 1'b0;
	localparam logic [CfgIdxBits-1:0] CfgTargetCh1 = 1'b1;

	typedef enum logic [1:0] {
		SignUnset = 2'd0,
		SignPos   = 2'd1,
		SignNeg   = 2'd2
	} sign_t;

	typedef struct packed {
		logic signed [SampleBits-1:0] sample_in;
		logic                         chan;
		logic                         clear_peak;
	} zcg_in_t;

	typedef struct packed {
		logic signed [SampleBits-1:0] sample_out;
		logic                         chan_out;
		logic        [SampleBits-1:0] peak_level;
		logic                         change_pending;
	} zcg_out_t;

endpackage

// ===== hw/rtl/zcg_gain_sat.sv =====
module zcg_gain_sat (
	input  logic signed [zcg_pkg::SampleBits-1:0] sample,
	input  logic        [zcg_pkg::GainBits-1:0]   gain,
	output logic signed [zcg_pkg::SampleBits-1:0] gained,
	output logic        [zcg_pkg::SampleBits-1:0] mag
);
	import zcg_pkg::*;

	localparam int ProdBits  = SampleBits + GainBits + 1;
	localparam int ShiftBits = ProdBits - GainFracBits;

	localparam logic signed [ShiftBits-1:0] SatHi = ShiftBits'((64'sd1 <<< (SampleBits - 1)) - 1);
	localparam logic signed [ShiftBits-1:0] SatLo = -SatHi - ShiftBits'(1);

	logic signed [ProdBits-1:0]  prod;
	logic signed [ShiftBits-1:0] shifted;

	// The arithmetic shift of the product rounds toward minus infinity.
	assign prod    = sample * $signed({1'b0, gain});
	assign shifted = prod[ProdBits-1:GainFracBits];

	always_comb begin
		if (shifted > SatHi) begin
			gained = SatHi[SampleBits-1:0];
		end else if (shifted < SatLo) begin
			gained = SatLo[SampleBits-1:0];
		end else begin
			gained = shifted[SampleBits-1:0];
		end
	end

	// Full-scale negative maps to 2^(SampleBits-1), which still fits unsigned.
	assign mag = gained[SampleBits-1] ? (~gained + SampleBits'(1)) : gained;

endmodule

// ===== hw/rtl/zero_cross_gain_with_peak.sv =====
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  in_word   (zcg_in_t)
// out       output     out_valid / out_stall out_word (zcg_out_t)
// cfg       input      cfg_we               cfg_index, cfg_data
//
// Each word is held in the input register and is then processed in a single pass
// into the output register, which offers its result. One word is accepted per cycle
// while in_stall is low; the per-channel gain, sign and peak state is read and
// written in that same pass, so back-to-back words of one channel see each other.
// A stall on the output holds the result register and, through it, the input register.
// Reset clears all valid flags, sets every gain to its default and clears the peak holds.
module zero_cross_gain_with_peak #(
	parameter int CHANNELS = zcg_pkg::ChannelsDefault
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  zcg_pkg::zcg_in_t                    in_word,
	output logic                                out_valid,
	input  logic                                out_stall,
	output zcg_pkg::zcg_out_t                   out_word,
	input  logic                                cfg_we,
	input  logic [zcg_pkg::CfgIdxBits-1:0]      cfg_index,
	input  logic [zcg_pkg::GainBits-1:0]        cfg_data
);
	import zcg_pkg::*;

	`include "zero_cross_gain_with_peak_assert.svh"

	localparam int ChIdxBits = 1;

	// Target gains are always kept for both channels, whatever CHANNELS is.
	logic [GainBits-1:0]   target_gain_q [2];
	logic [GainBits-1:0]   applied_gain_q [CHANNELS];
	sign_t                 sign_ref_q [CHANNELS];
	logic [SampleBits-1:0] peak_hold_q [CHANNELS];

	zcg_in_t  in_s1;
	logic     valid_s1;
	zcg_out_t out_q;
	logic     out_valid_q;

	logic                         advance;
	logic [ChIdxBits-1:0]         ch_sel;
	logic [GainBits-1:0]          tgt;
	logic [GainBits-1:0]          app;
	sign_t                        cur_ref;
	sign_t                        sample_sign;
	sign_t                        eff_ref;
	sign_t                        next_ref;
	logic                         pending;
	logic                         is_zero;
	logic                         apply;
	logic [GainBits-1:0]          gain_use;
	logic signed [SampleBits-1:0] gained;
	logic [SampleBits-1:0]        mag;
	logic [SampleBits-1:0]        peak_new;

	// A held word moves on when the result register is empty or being taken.
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// A channel number beyond the configured count folds onto the last channel.
	always_comb begin
		if (int'(in_s1.chan) >= CHANNELS) begin
			ch_sel = ChIdxBits'(CHANNELS - 1);
		end else begin
			ch_sel = in_s1.chan;
		end
	end

	assign tgt     = target_gain_q[ch_sel];
	assign app     = applied_gain_q[ch_sel];
	assign cur_ref = sign_ref_q[ch_sel];
	assign pending = (tgt != app);
	assign is_zero = (in_s1.sample_in == '0);

	// Zero counts as negative for the reference, but a zero sample always applies the
	// pending gain. A sign that differs from the reference marks the zero crossing.
	always_comb begin
		sample_sign = (!in_s1.sample_in[SampleBits-1] && !is_zero) ? SignPos : SignNeg;
		eff_ref     = (cur_ref == SignUnset) ? sample_sign : cur_ref;
		apply       = pending && ((sample_sign != eff_ref) || is_zero);
		if (!pending) begin
			next_ref = cur_ref;
		end else if (apply) begin
			next_ref = SignUnset;
		end else begin
			next_ref = sample_sign;
		end
		gain_use = apply ? tgt : app;
	end

	zcg_gain_sat u_gain_sat (
		.sample (in_s1.sample_in),
		.gain   (gain_use),
		.gained (gained),
		.mag    (mag)
	);

	assign peak_new = (mag > peak_hold_q[ch_sel]) ? mag : peak_hold_q[ch_sel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_gain_q[0] <= GainReset;
			target_gain_q[1] <= GainReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgTargetCh0: target_gain_q[0] <= cfg_data;
				CfgTargetCh1: target_gain_q[1] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				applied_gain_q[c] <= GainReset;
				sign_ref_q[c]     <= SignUnset;
				peak_hold_q[c]    <= '0;
			end
		end else if (advance) begin
			applied_gain_q[ch_sel] <= gain_use;
			sign_ref_q[ch_sel]     <= next_ref;
			peak_hold_q[ch_sel]    <= in_s1.clear_peak ? '0 : peak_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			in_s1 <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.sample_out     <= gained;
			out_q.chan_out       <= ch_sel;
			out_q.peak_level     <= peak_new;
			out_q.change_pending <= (tgt != gain_use);
		end
	end

	`ZCG_ASSERT(a_stall_needs_word, !in_stall || valid_s1, "input stalled with an empty stage")
	`ZCG_ASSERT_NEXT(a_result_from_stage, !out_valid_q && !advance, !out_valid_q,
		"result appeared without a processed word")
	`ZCG_ASSERT_NEXT(a_gain_written, advance, applied_gain_q[$past(ch_sel)] == $past(gain_use),
		"applied gain not updated after a word")
	`ZCG_ASSERT_NEXT(a_peak_cleared, advance && in_s1.clear_peak,
		peak_hold_q[$past(ch_sel)] == '0, "peak hold not cleared on request")

endmodule
